>>> sv/can_frame_change_tracker_macros.svh
// Assertion macros for the CAN frame change tracker.
// Used by the top level only; defining ASSERT_OFF empties every macro.
`ifndef CAN_FRAME_CHANGE_TRACKER_MACROS_SVH
`define CAN_FRAME_CHANGE_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge out of reset.
`define CFCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfct assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define CFCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfct assertion failed");

`else

`define CFCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/cfct_pkg.sv
// Shared constants, status codes and controller/datapath interface structs
// for the CAN frame change tracker. No dependencies.
`timescale 1ns / 1ps

package cfct_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IFACE_COUNT = 8;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int IFACE_W = 3;
    localparam int ID_W    = 32;
    localparam int DLC_W   = 4;
    localparam int DATA_W  = 64;
    localparam int STAMP_W = 32;
    localparam int AVG_W   = 32;
    localparam int TAG_W   = 32;
    localparam int MASK_W  = 8;
    localparam int EN_W    = 8;
    localparam int KEY_W   = IFACE_W + ID_W;
    localparam int ENT_W   = AVG_W + STAMP_W + DATA_W;

    localparam logic [DLC_W-1:0] MAX_DLC = DLC_W'(8);

    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_DISABLED = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef struct packed {
        logic load;       // latch the input frame, restart the search pointer
        logic key_rd;     // read the key at the search pointer, advance it
        logic hit;        // capture the index of the matching key
        logic ent_rd;     // read the entry at the hit index
        logic calc;       // register interval and change mask
        logic emit_drop;  // result: interface not enabled
        logic emit_full;  // result: table full
        logic store_new;  // create a new entry and report it
        logic store_upd;  // update the hit entry and report it
    } t_cmd;

    typedef struct packed {
        logic en_ok;      // frame interface is enabled
        logic used_zero;  // table is empty
        logic more;       // keys remain to be read
        logic match;      // last key read equals the frame key
        logic full;       // no free entry left
    } t_sts;

endpackage

>>> sv/can_frame_change_tracker.sv
// A frame on a disabled interface is dropped in CHECK, after IDLE; the key search reads
// the key memory one entry per cycle, so a new frame is compared with every entry in use before
// NEW (none on an empty table), and a known frame stops at its entry, then runs READ, DIFF, UPD.
// o_busy stays high for the whole search, so a new frame is accepted only once the last is done;
// the result strobe lasts one cycle and cannot be stalled.
// Reset (synchronous, active low) empties the table, zeroes the tag and disables all interfaces.
`timescale 1ns / 1ps
`include "can_frame_change_tracker_macros.svh"

module can_frame_change_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cfct_pkg::EN_W-1:0]     i_cfg_wdata,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [cfct_pkg::IFACE_W-1:0]  i_iface,
    input  logic [cfct_pkg::ID_W-1:0]     i_frame_id,
    input  logic [cfct_pkg::DLC_W-1:0]    i_dlc,
    input  logic [cfct_pkg::DATA_W-1:0]   i_payload,
    input  logic [cfct_pkg::STAMP_W-1:0]  i_stamp,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic                          o_is_new,
    output logic [cfct_pkg::MASK_W-1:0]   o_change_mask,
    output logic [cfct_pkg::AVG_W-1:0]    o_avg_interval,
    output logic [cfct_pkg::TAG_W-1:0]    o_tag
);
    import cfct_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    cfct_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (s_sts),
        .o_cmd   (s_cmd),
        .o_busy  (o_busy)
    );

    cfct_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (s_cmd),
        .o_sts          (s_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_iface        (i_iface),
        .i_frame_id     (i_frame_id),
        .i_dlc          (i_dlc),
        .i_payload      (i_payload),
        .i_stamp        (i_stamp),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_is_new       (o_is_new),
        .o_change_mask  (o_change_mask),
        .o_avg_interval (o_avg_interval),
        .o_tag          (o_tag)
    );

    // A result is reported only once the controller has returned to idle.
    `CFCT_ASSERT_IMP(a_valid_idle, i_clk, i_rst_n, o_valid, !o_busy)
    // Each transfer produces a single one-cycle strobe.
    `CFCT_ASSERT_NXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // An accepted frame always starts work on the next cycle.
    `CFCT_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy && !o_valid)
    // Only one memory write source may be active at a time.
    `CFCT_ASSERT_IMP(a_one_store, i_clk, i_rst_n, s_cmd.store_new, !s_cmd.store_upd)

endmodule

>>> sv/cfct_ctrl.sv
// Controller state machine for the CAN frame change tracker.
// Depends on cfct_pkg for the command and status structs.
`timescale 1ns / 1ps

module cfct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  cfct_pkg::t_sts i_sts,
    output cfct_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import cfct_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_NEW   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DIFF  = 3'd5;
    localparam logic [2:0] S_UPD   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       s_cmd;

    always_comb begin
        n_state = r_state;
        s_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    s_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.en_ok) begin
                    s_cmd.emit_drop = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_sts.used_zero) begin
                    n_state = S_NEW;
                end else begin
                    s_cmd.key_rd = 1'b1;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // One key is compared per cycle while the next one is read.
                if (i_sts.match) begin
                    s_cmd.hit = 1'b1;
                    n_state   = S_READ;
                end else if (i_sts.more) begin
                    s_cmd.key_rd = 1'b1;
                end else begin
                    n_state = S_NEW;
                end
            end
            S_NEW: begin
                if (i_sts.full) begin
                    s_cmd.emit_full = 1'b1;
                end else begin
                    s_cmd.store_new = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_READ: begin
                s_cmd.ent_rd = 1'b1;
                n_state      = S_DIFF;
            end
            S_DIFF: begin
                s_cmd.calc = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                s_cmd.store_upd = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = s_cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

>>> sv/cfct_dp.sv
// Datapath for the CAN frame change tracker: key and entry memories,
// counters, interval and change-mask arithmetic, result registers. Uses cfct_pkg.
`timescale 1ns / 1ps

module cfct_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfct_pkg::t_cmd                i_cmd,
    output cfct_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [cfct_pkg::EN_W-1:0]     i_cfg_wdata,
    input  logic [cfct_pkg::IFACE_W-1:0]  i_iface,
    input  logic [cfct_pkg::ID_W-1:0]     i_frame_id,
    input  logic [cfct_pkg::DLC_W-1:0]    i_dlc,
    input  logic [cfct_pkg::DATA_W-1:0]   i_payload,
    input  logic [cfct_pkg::STAMP_W-1:0]  i_stamp,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic                          o_is_new,
    output logic [cfct_pkg::MASK_W-1:0]   o_change_mask,
    output logic [cfct_pkg::AVG_W-1:0]    o_avg_interval,
    output logic [cfct_pkg::TAG_W-1:0]    o_tag
);
    import cfct_pkg::*;

    // Memories: keys and {avg, stamp, data} per entry.
    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [ENT_W-1:0] ent_mem [TABLE_DEPTH];

    logic [EN_W-1:0]    r_enable;
    logic [CNT_W-1:0]   r_used;
    logic [TAG_W-1:0]   r_tag;
    logic [CNT_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]  r_cmp_idx;
    logic [ADDR_W-1:0]  r_hit;
    logic [KEY_W-1:0]   r_key_rd;
    logic [ENT_W-1:0]   r_ent_rd;

    logic [IFACE_W-1:0] r_iface;
    logic [ID_W-1:0]    r_id;
    logic [DLC_W-1:0]   r_dlc;
    logic [DATA_W-1:0]  r_payload;
    logic [STAMP_W-1:0] r_stamp;

    logic [STAMP_W-1:0] r_diff;
    logic [MASK_W-1:0]  r_mask;

    logic               r_valid;
    logic [1:0]         r_status;
    logic               r_is_new;
    logic [MASK_W-1:0]  r_res_mask;
    logic [AVG_W-1:0]   r_res_avg;
    logic [TAG_W-1:0]   r_res_tag;

    logic [DLC_W-1:0]   s_len;
    logic [MASK_W-1:0]  s_mask;
    logic [AVG_W:0]     s_sum;
    logic               s_wr;
    logic [ADDR_W-1:0]  s_wr_addr;
    logic [ENT_W-1:0]   s_wr_data;

    always_comb begin
        o_sts.en_ok     = (32'(r_iface) < IFACE_COUNT) && r_enable[r_iface];
        o_sts.used_zero = (r_used == '0);
        o_sts.more      = (r_ptr < r_used);
        o_sts.match     = (r_key_rd == {r_iface, r_id});
        o_sts.full      = (r_used == CNT_W'(TABLE_DEPTH));
    end

    // Lengths above eight compare all eight bytes.
    assign s_len = (r_dlc > MAX_DLC) ? MAX_DLC : r_dlc;

    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            s_mask[i] = (DLC_W'(i) < s_len) &&
                        (r_payload[8*i +: 8] != r_ent_rd[8*i +: 8]);
        end
    end

    // Sum is one bit wider than the operands, so halving never overflows.
    assign s_sum = {1'b0, r_diff} + {1'b0, r_ent_rd[ENT_W-1 -: AVG_W]};

    assign s_wr      = i_cmd.store_new || (i_cmd.store_upd);
    assign s_wr_addr = i_cmd.store_new ? r_used[ADDR_W-1:0] : r_hit;
    assign s_wr_data = i_cmd.store_new ? {{AVG_W{1'b0}}, r_stamp, r_payload}
                                       : {s_sum[AVG_W:1], r_stamp, r_payload};

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_new) begin
            key_mem[r_used[ADDR_W-1:0]] <= {r_iface, r_id};
        end
        if (i_cmd.key_rd) begin
            r_key_rd <= key_mem[r_ptr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            ent_mem[s_wr_addr] <= s_wr_data;
        end
        if (i_cmd.ent_rd) begin
            r_ent_rd <= ent_mem[r_hit];
        end
    end

    // Frame latch and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_iface   <= i_iface;
            r_id      <= i_frame_id;
            r_dlc     <= i_dlc;
            r_payload <= i_payload;
            r_stamp   <= i_stamp;
        end
        if (i_cmd.key_rd) begin
            r_cmp_idx <= r_ptr[ADDR_W-1:0];
        end
        if (i_cmd.hit) begin
            r_hit <= r_cmp_idx;
        end
        if (i_cmd.calc) begin
            r_diff <= r_stamp - r_ent_rd[DATA_W +: STAMP_W];
            r_mask <= s_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= '0;
            r_used   <= '0;
            r_tag    <= '0;
            r_ptr    <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else if (i_cmd.key_rd) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (i_cmd.store_new) begin
                r_used <= r_used + 1'b1;
            end
            if (i_cmd.store_new || i_cmd.store_upd) begin
                r_tag <= r_tag + 1'b1;
            end
            r_valid <= i_cmd.emit_drop || i_cmd.emit_full ||
                       i_cmd.store_new || i_cmd.store_upd;
        end
    end

    // Result payload registers; only the strobe needs a reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_drop) begin
            r_status   <= ST_DISABLED;
            r_is_new   <= 1'b0;
            r_res_mask <= '0;
            r_res_avg  <= '0;
            r_res_tag  <= '0;
        end else if (i_cmd.emit_full) begin
            r_status   <= ST_FULL;
            r_is_new   <= 1'b1;
            r_res_mask <= '0;
            r_res_avg  <= '0;
            r_res_tag  <= '0;
        end else if (i_cmd.store_new) begin
            r_status   <= ST_STORED;
            r_is_new   <= 1'b1;
            r_res_mask <= '0;
            r_res_avg  <= '0;
            r_res_tag  <= r_tag;
        end else if (i_cmd.store_upd) begin
            r_status   <= ST_STORED;
            r_is_new   <= 1'b0;
            r_res_mask <= r_mask;
            r_res_avg  <= s_sum[AVG_W:1];
            r_res_tag  <= r_tag;
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_is_new       = r_is_new;
    assign o_change_mask  = r_res_mask;
    assign o_avg_interval = r_res_avg;
    assign o_tag          = r_res_tag;

endmodule

>>> dv/can_frame_change_tracker_test.sv
// Self-checking testbench for can_frame_change_tracker: a directed table, then random frames.
// Results are checked against a behavioral table model or typed reports. Depends on cfct_pkg.
`timescale 1ns / 1ps

module can_frame_change_tracker_test;

    import cfct_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_FRAMES = 2000;
    localparam int PHASES        = 6;
    localparam int MAX_GAP       = 11;
    localparam int DRAIN_CYCLES  = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DIR_ROWS      = 21;

    localparam logic [DATA_W-1:0] ONES64 = '1;
    localparam logic [ID_W-1:0]   ONES32 = '1;

    typedef struct packed {
        logic [IFACE_W-1:0] iface;
        logic [ID_W-1:0]    frame_id;
        logic [DLC_W-1:0]   dlc;
        logic [DATA_W-1:0]  payload;
        logic [STAMP_W-1:0] stamp;
    } t_can_frame;

    typedef struct packed {
        logic [1:0]        status;
        logic              is_new;
        logic [MASK_W-1:0] change_mask;
        logic [AVG_W-1:0]  avg_interval;
        logic [TAG_W-1:0]  tag;
    } t_frame_report;

    typedef enum logic {ROW_FRAME, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind       kind;
        logic [EN_W-1:0] enable;
        t_can_frame      frame;
        bit              typed;
        t_frame_report   report;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [EN_W-1:0]     i_cfg_wdata;
    logic                i_start;
    logic                o_busy;
    logic [IFACE_W-1:0]  i_iface;
    logic [ID_W-1:0]     i_frame_id;
    logic [DLC_W-1:0]    i_dlc;
    logic [DATA_W-1:0]   i_payload;
    logic [STAMP_W-1:0]  i_stamp;
    logic                o_valid;
    logic [1:0]          o_status;
    logic                o_is_new;
    logic [MASK_W-1:0]   o_change_mask;
    logic [AVG_W-1:0]    o_avg_interval;
    logic [TAG_W-1:0]    o_tag;

    can_frame_change_tracker i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_iface        (i_iface),
        .i_frame_id     (i_frame_id),
        .i_dlc          (i_dlc),
        .i_payload      (i_payload),
        .i_stamp        (i_stamp),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_is_new       (o_is_new),
        .o_change_mask  (o_change_mask),
        .o_avg_interval (o_avg_interval),
        .o_tag          (o_tag)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Model of the frame table. Entries fill in order, so slots below used_count are valid.
    logic [IFACE_W-1:0] key_iface [TABLE_DEPTH];
    logic [ID_W-1:0]    key_id    [TABLE_DEPTH];
    logic [DATA_W-1:0]  data_mem  [TABLE_DEPTH];
    logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];
    logic [AVG_W-1:0]   avg_mem   [TABLE_DEPTH];
    int                 used_count = 0;
    logic [TAG_W-1:0]   tag_counter = '0;
    logic [EN_W-1:0]    enable_bits = '0;

    t_frame_report expected_reports [$];
    int error_count   = 0;
    int cycle_count   = 0;
    int n_created     = 0;
    int n_updated     = 0;
    int n_dropped     = 0;
    int n_full        = 0;
    int enable_writes = 0;
    bit burst_mode    = 1'b0;

    function automatic t_frame_report track_frame(input t_can_frame f);
        t_frame_report r;
        int slot;
        int len;
        int i;
        logic [STAMP_W-1:0] diff;
        logic [AVG_W:0]     sum;
        r = '0;
        r.status = ST_STORED;
        if (int'(f.iface) >= IFACE_COUNT || !enable_bits[f.iface]) begin
            r.status = ST_DISABLED;
            return r;
        end
        slot = -1;
        for (i = 0; i < used_count; i++) begin
            if (slot < 0 && key_iface[i] == f.iface && key_id[i] == f.frame_id)
                slot = i;
        end
        if (slot < 0) begin
            r.is_new = 1'b1;
            if (used_count >= TABLE_DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            slot = used_count;
            used_count++;
            key_iface[slot] = f.iface;
            key_id[slot] = f.frame_id;
        end else begin
            // The sum is kept one bit wider so the halving never loses the carry.
            diff = f.stamp - stamp_mem[slot];
            sum = {1'b0, diff} + {1'b0, avg_mem[slot]};
            r.avg_interval = sum[AVG_W:1];
            len = (f.dlc > MAX_DLC) ? int'(MAX_DLC) : int'(f.dlc);
            for (i = 0; i < len; i++) begin
                if (f.payload[8*i +: 8] != data_mem[slot][8*i +: 8])
                    r.change_mask[i] = 1'b1;
            end
        end
        r.tag = tag_counter;
        tag_counter = tag_counter + 1'b1;
        data_mem[slot] = f.payload;
        stamp_mem[slot] = f.stamp;
        avg_mem[slot] = r.avg_interval;
        return r;
    endfunction

    function automatic t_dir_row frame_row(input logic [IFACE_W-1:0] iface,
                                           input logic [ID_W-1:0] id,
                                           input logic [DLC_W-1:0] dlc,
                                           input logic [DATA_W-1:0] payload,
                                           input logic [STAMP_W-1:0] stamp);
        t_dir_row r;
        r.kind = ROW_FRAME;
        r.enable = '0;
        r.frame = '{iface, id, dlc, payload, stamp};
        r.typed = 1'b0;
        r.report = '0;
        return r;
    endfunction

    function automatic t_dir_row typed_row(input logic [IFACE_W-1:0] iface,
                                           input logic [ID_W-1:0] id,
                                           input logic [DLC_W-1:0] dlc,
                                           input logic [DATA_W-1:0] payload,
                                           input logic [STAMP_W-1:0] stamp,
                                           input logic [1:0] status,
                                           input logic is_new,
                                           input logic [MASK_W-1:0] mask,
                                           input logic [AVG_W-1:0] avg,
                                           input logic [TAG_W-1:0] tag);
        t_dir_row r;
        r = frame_row(iface, id, dlc, payload, stamp);
        r.typed = 1'b1;
        r.report = '{status, is_new, mask, avg, tag};
        return r;
    endfunction

    function automatic t_dir_row config_row(input logic [EN_W-1:0] value);
        t_dir_row r;
        r = frame_row('0, '0, '0, '0, '0);
        r.kind = ROW_CONFIG;
        r.enable = value;
        return r;
    endfunction

    function automatic t_dir_row directed_row(input int n);
        t_dir_row r;
        case (n)
            // Nothing is enabled after reset.
            0:  r = typed_row(3'd0, 32'h0, 4'd0, 64'h0, 32'h0,
                              ST_DISABLED, 1'b0, 8'h0, 32'h0, 32'd0);
            1:  r = typed_row(3'd7, ONES32, 4'd8, ONES64, ONES32,
                              ST_DISABLED, 1'b0, 8'h0, 32'h0, 32'd0);
            2:  r = config_row(8'hFF);
            3:  r = typed_row(3'd0, 32'h0, 4'd8, 64'h0, 32'h0,
                              ST_STORED, 1'b1, 8'h0, 32'h0, 32'd0);
            4:  r = typed_row(3'd7, ONES32, 4'd8, ONES64, ONES32,
                              ST_STORED, 1'b1, 8'h0, 32'h0, 32'd1);
            5:  r = typed_row(3'd0, 32'h0, 4'd8, ONES64, ONES32,
                              ST_STORED, 1'b0, 8'hFF, 32'h7FFF_FFFF, 32'd2);
            // Length above eight, then an interval that wraps and a sum that needs 33 bits.
            6:  r = frame_row(3'd7, ONES32, 4'd15, 64'h0, 32'hFFFF_FFFE);
            7:  r = frame_row(3'd7, ONES32, 4'd4, 64'h5555_5555_5555_5555, 32'hFFFF_FFFD);
            8:  r = frame_row(3'd7, ONES32, 4'd0, 64'h0123_4567_89AB_CDEF, 32'h0);
            // Only a byte at or above the length changes.
            9:  r = frame_row(3'd7, ONES32, 4'd1, 64'h0123_4567_89AB_00EF, 32'h1);
            // The same identifier on another interface is a separate entry.
            10: r = frame_row(3'd1, 32'h0, 4'd2, 64'h0, 32'd100);
            11: r = frame_row(3'd0, 32'h8000_0000, 4'd8, 64'hA5A5_A5A5_A5A5_A5A5, 32'd200);
            12: r = frame_row(3'd0, 32'h8000_0000, 4'd8, 64'hA5A5_A5A5_A5A5_A5A5, 32'd200);
            13: r = config_row(8'h01);
            14: r = typed_row(3'd1, 32'h0, 4'd2, 64'h0, 32'd300,
                              ST_DISABLED, 1'b0, 8'h0, 32'h0, 32'd0);
            15: r = frame_row(3'd0, 32'h0, 4'd3, 64'h1, 32'd5);
            16: r = config_row(8'h80);
            17: r = typed_row(3'd0, 32'h0, 4'd8, ONES64, 32'd6,
                              ST_DISABLED, 1'b0, 8'h0, 32'h0, 32'd0);
            18: r = frame_row(3'd7, ONES32, 4'd8, ONES64, 32'd10);
            19: r = config_row(8'h00);
            default: r = typed_row(3'd3, 32'h0001_2345, 4'd8, ONES64, ONES32,
                                   ST_DISABLED, 1'b0, 8'h0, 32'h0, 32'd0);
        endcase
        return r;
    endfunction

    function automatic t_can_frame random_frame();
        t_can_frame f;
        int pick;
        int slot;
        int nbytes;
        int k;
        pick = $urandom_range(0, 99);
        f.iface = IFACE_W'($urandom_range(0, 7));
        f.frame_id = $urandom;
        f.dlc = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                            : 4'($urandom_range(0, 8));
        f.payload = {$urandom, $urandom};
        f.stamp = $urandom;
        if (used_count > 0 && pick < 70) begin
            // A known entry, usually with a few bytes changed and a plausible interval.
            slot = $urandom_range(0, used_count - 1);
            f.iface = key_iface[slot];
            f.frame_id = key_id[slot];
            if ($urandom_range(0, 3) != 0) begin
                f.payload = data_mem[slot];
                nbytes = $urandom_range(0, 3);
                for (k = 0; k < nbytes; k++)
                    f.payload[8*$urandom_range(0, 7) +: 8] = 8'($urandom);
            end
            if ($urandom_range(0, 3) != 0)
                f.stamp = stamp_mem[slot] + $urandom_range(0, 5000);
        end else if (used_count > 0 && pick < 80) begin
            f.frame_id = key_id[$urandom_range(0, used_count - 1)];
        end else if (pick >= 96) begin
            f.frame_id = $urandom_range(0, 1) ? '0 : ONES32;
        end
        return f;
    endfunction

    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Presents one frame after the given number of idle cycles and records its expected report.
    task automatic send_frame(input t_can_frame f, input int gap,
                              input bit typed, input t_frame_report typed_report);
        t_frame_report r;
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start    <= 1'b1;
        i_iface    <= f.iface;
        i_frame_id <= f.frame_id;
        i_dlc      <= f.dlc;
        i_payload  <= f.payload;
        i_stamp    <= f.stamp;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        r = track_frame(f);
        case (r.status)
            ST_DISABLED: n_dropped++;
            ST_FULL:     n_full++;
            default: begin
                if (r.is_new) n_created++;
                else          n_updated++;
            end
        endcase
        expected_reports.insert(expected_reports.size(), typed ? typed_report : r);
    endtask

    task automatic drain_reports();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (expected_reports.size() != 0 || o_busy) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic [EN_W-1:0] value);
        drain_reports();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        enable_bits = value;
        enable_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_report e;
        if (i_rst_n && o_valid) begin
            if (expected_reports.size() == 0) begin
                $error("report with no frame outstanding: status %0d, tag 0x%0h",
                       o_status, o_tag);
                error_count++;
            end else begin
                e = expected_reports.pop_front();
                check_field("status", 32'(e.status), 32'(o_status));
                check_field("is_new", 32'(e.is_new), 32'(o_is_new));
                check_field("change_mask", 32'(e.change_mask), 32'(o_change_mask));
                check_field("avg_interval", e.avg_interval, o_avg_interval);
                check_field("tag", e.tag, o_tag);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("can_frame_change_tracker test failed");
            $finish;
        end
    end

    initial begin
        t_dir_row row;
        int n;
        int p;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_start     = 1'b0;
        i_iface     = '0;
        i_frame_id  = '0;
        i_dlc       = '0;
        i_payload   = '0;
        i_stamp     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++) begin
            row = directed_row(n);
            if (row.kind == ROW_CONFIG)
                write_enable(row.enable);
            else
                send_frame(row.frame, $urandom_range(0, MAX_GAP), row.typed, row.report);
        end

        // Phases alternate between all interfaces enabled and a random subset.
        for (p = 0; p < PHASES; p++) begin
            write_enable((p % 2 == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
            for (n = 0; n < RANDOM_FRAMES / PHASES; n++) begin
                if (n % 48 == 0)
                    burst_mode = ($urandom_range(0, 3) == 0);
                if (p == 2 && n == RANDOM_FRAMES / (2 * PHASES))
                    drain_reports();
                send_frame(random_frame(), draw_gap(), 1'b0, '0);
            end
        end
        drain_reports();

        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            error_count++;
        end
        $display("Sent %0d frames: %0d created entries, %0d updates, %0d dropped, %0d full.",
                 n_created + n_updated + n_dropped + n_full,
                 n_created, n_updated, n_dropped, n_full);
        $display("Applied %0d interface enable settings; %0d of %0d entries in use at the end.",
                 enable_writes, used_count, TABLE_DEPTH);
        if (error_count == 0) begin
            $display("can_frame_change_tracker test passed");
        end else begin
            $display("can_frame_change_tracker test failed");
        end
        $finish;
    end

endmodule
